// File: rtl/core/pblep_pkg.sv
// Shared constants and codes for the polyBLEP oscillator.
// No dependencies; used by the divider, the top level and the checker.
`timescale 1ns / 1ps

package pblep_pkg;

   // field widths fixed by the interface
   localparam int IN_W  = 24;
   localparam int OUT_W = 24;

   // default phase accumulator fraction bits
   localparam int PHASE_BITS_DEFAULT = 24;

   // fraction bits of the residual ratio and of the output
   localparam int QBITS = 20;

   // 1.0 in Q3.20
   localparam logic [OUT_W-1:0] Q_ONE = OUT_W'(1 << QBITS);

   // waveform register codes
   localparam logic WAVE_SAW    = 1'b0;
   localparam logic WAVE_SQUARE = 1'b1;

endpackage

// File: rtl/core/pblep_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^QBITS / den).
// Expects num < den; depends on pblep_pkg.
`timescale 1ns / 1ps

module pblep_div #(
   parameter int PHASE_BITS = pblep_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [PHASE_BITS-1:0]       num,
   input  logic [PHASE_BITS-1:0]       den,
   output logic [pblep_pkg::QBITS-1:0] quo,
   output logic                        done
);

   localparam int QB   = pblep_pkg::QBITS;
   localparam int CntW = $clog2(QB);
   localparam logic [CntW-1:0] LastStep = CntW'(QB - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [PHASE_BITS-1:0] rem_ff, rem_in;
   logic [QB-1:0]         quo_ff, quo_in;
   logic [PHASE_BITS:0]   rem_sh;
   logic [PHASE_BITS:0]   rem_sub;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      ge      = rem_sh >= {1'b0, den};
      rem_sub = rem_sh - {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         quo_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below den, so it fits the narrow register
         rem_in = ge ? rem_sub[PHASE_BITS-1:0] : rem_sh[PHASE_BITS-1:0];
         quo_in = {quo_ff[QB-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// File: rtl/core/polyblep_oscillator.sv
// PolyBLEP sawtooth / variable-width square oscillator, top level.
// Sequencer, phase accumulator and output register; uses pblep_pkg and pblep_div.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_phase_step, req_pulse_width
//   rsp      out        rsp_valid / rsp_stall   rsp_sample
//   csr      in         csr_wr_en               csr_wr_data (waveform)
//
// Each residual term takes a setup step, the shared divider, a product step
// and an accumulate step.
// A term whose phase is outside the transition region skips the divider.
// req_stall is high while an item is in work; a result waiting on rsp_stall
// holds the next result in the final state, and reset clears phase and waveform.
`timescale 1ns / 1ps

module polyblep_oscillator #(
   parameter int PHASE_BITS = pblep_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pblep_pkg::IN_W-1:0]        req_phase_step,
   input  logic [pblep_pkg::IN_W-1:0]        req_pulse_width,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pblep_pkg::OUT_W-1:0] rsp_sample,
   input  logic                              csr_wr_en,
   input  logic [0:0]                        csr_wr_data
);

   localparam int QB    = pblep_pkg::QBITS;
   localparam int OW    = pblep_pkg::OUT_W;
   localparam int ExtW  = (PHASE_BITS > pblep_pkg::IN_W) ? PHASE_BITS : pblep_pkg::IN_W;
   localparam int ProdW = 2 * QB + 1;

   localparam logic [PHASE_BITS-1:0] HalfCycle = {1'b1, {(PHASE_BITS-1){1'b0}}};
   localparam logic [QB:0]           RatioOne  = (QB+1)'(1 << QB);
   localparam logic [ProdW-1:0]      RoundHalf = ProdW'(1 << (QB - 1));

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_ACCUM  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  wave_ff, wave_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  pass_ff, pass_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PHASE_BITS-1:0] dt_ff, dt_in;
   logic [PHASE_BITS-1:0] t_ff, t_in;
   logic [PHASE_BITS-1:0] t2_ff, t2_in;
   logic [OW-1:0]         acc_ff, acc_in;
   logic                  add_ff, add_in;
   logic [ProdW-1:0]      prod_ff, prod_in;
   logic [OW-1:0]         rsp_sample_ff, rsp_sample_in;

   logic [ExtW-1:0]       step_ext;
   logic [ExtW-1:0]       width_ext;
   logic [PHASE_BITS-1:0] dt_new;
   logic [PHASE_BITS-1:0] pw_new;
   logic [QB-1:0]         t_q20;
   logic                  over_half;
   logic [OW-1:0]         saw_init;
   logic [OW-1:0]         level;

   logic [PHASE_BITS-1:0] x;
   logic [PHASE_BITS:0]   x_sum;
   logic                  below_dt;
   logic                  above_top;
   logic                  last_pass;
   logic [PHASE_BITS-1:0] div_num;
   logic                  div_start;
   logic                  div_done;
   logic [QB-1:0]         div_quo;
   logic [QB:0]           ratio_rest;
   logic [ProdW-1:0]      rounded;
   logic [OW-1:0]         blep_sq;

   pblep_div #(
      .PHASE_BITS(PHASE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dt_ff),
      .quo   (div_quo),
      .done  (div_done)
   );

   // phase to Q0.20
   if (PHASE_BITS >= QB) begin : g_q20_shr
      assign t_q20 = phase_ff[PHASE_BITS-1 -: QB];
   end else begin : g_q20_shl
      assign t_q20 = {phase_ff, {(QB-PHASE_BITS){1'b0}}};
   end

   always_comb begin
      step_ext  = ExtW'(req_phase_step);
      width_ext = ExtW'(req_pulse_width);
      dt_new    = step_ext[PHASE_BITS-1:0];
      pw_new    = width_ext[PHASE_BITS-1:0];
      // compare against half + pw without wrap
      over_half = {1'b0, phase_ff} > ({1'b0, HalfCycle} + {1'b0, pw_new});
      saw_init  = OW'({t_q20, 1'b0}) - pblep_pkg::Q_ONE;
      level     = over_half ? (OW'(0) - pblep_pkg::Q_ONE) : pblep_pkg::Q_ONE;

      x         = pass_ff ? t2_ff : t_ff;
      x_sum     = {1'b0, x} + {1'b0, dt_ff};
      below_dt  = x < dt_ff;
      // x > one - dt, false for a zero increment
      above_top = x_sum[PHASE_BITS] && (x_sum[PHASE_BITS-1:0] != '0);
      div_num   = below_dt ? x : (PHASE_BITS'(0) - x);
      // the sawtooth subtracts its only term, the square subtracts its second
      last_pass = (wave_ff == pblep_pkg::WAVE_SAW) || pass_ff;

      ratio_rest = RatioOne - {1'b0, div_quo};
      rounded    = prod_ff + RoundHalf;
      blep_sq    = OW'(rounded[ProdW-1:QB]);

      state_in      = state_ff;
      wave_in       = wave_ff;
      phase_in      = phase_ff;
      pass_in       = pass_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      dt_in         = dt_ff;
      t_in          = t_ff;
      t2_in         = t2_ff;
      acc_in        = acc_ff;
      add_in        = add_ff;
      prod_in       = prod_ff;
      rsp_sample_in = rsp_sample_ff;
      div_start     = 1'b0;

      if (csr_wr_en) begin
         wave_in = csr_wr_data[0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dt_in    = dt_new;
               t_in     = phase_ff;
               t2_in    = phase_ff + HalfCycle - pw_new;
               phase_in = phase_ff + dt_new;
               acc_in   = (wave_ff == pblep_pkg::WAVE_SAW) ? saw_init : level;
               pass_in  = 1'b0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (below_dt || above_top) begin
               div_start = 1'b1;
               // term is added when its sign and the subtract flag agree
               add_in    = (below_dt == last_pass);
               state_in  = ST_DIV;
            end else if (last_pass) begin
               state_in = ST_FINISH;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               prod_in  = ProdW'(ratio_rest) * ProdW'(ratio_rest);
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            acc_in = add_ff ? (acc_ff + blep_sq) : (acc_ff - blep_sq);
            if (last_pass) begin
               state_in = ST_FINISH;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = acc_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wave_ff      <= pblep_pkg::WAVE_SAW;
         phase_ff     <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wave_ff      <= wave_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff         <= dt_in;
      t_ff          <= t_in;
      t2_ff         <= t2_in;
      acc_ff        <= acc_in;
      add_ff        <= add_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = $signed(rsp_sample_ff);

endmodule

// File: rtl/core/pblep_checker.sv
// Port-level checks for the polyBLEP oscillator, bound to the top level.
// Depends on pblep_pkg for field widths.
`timescale 1ns / 1ps

module pblep_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [pblep_pkg::OUT_W-1:0]  rsp_sample
);

   // a result held back keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled result changed");

   // an accepted item keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting an item");

   // a new result appears exactly when the block frees up
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $fell(req_stall))
      else $error("result appeared while block still busy");

   // freeing up always leaves a result on the output
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("block went idle without a result");

endmodule

bind polyblep_oscillator pblep_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sample (rsp_sample)
);
